>>> rtl/hrtc_pkg.sv
// Shared types, codes and sizing constants for the host region table checker.
// Used by hrtc_cmp and the top level; depends on nothing.
package hrtc_pkg;

  localparam int ENTRIES    = 32;
  localparam int PAGE_BYTES = 4096;
  localparam int ADDR_BITS  = 48;
  localparam int IDX_W      = $clog2(ENTRIES);
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int END_W      = ADDR_BITS + 1;
  localparam int TOTAL_W    = 53;
  localparam int CFG_W      = 49;

  localparam logic [ADDR_BITS-1:0] GUEST_BASE_RESET  = '0;
  localparam logic [END_W-1:0]     GUEST_LIMIT_RESET = 49'h0_0020_0000_0000;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_MAP    = 2'd2,
    OP_UNMAP  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_INVALID  = 3'd1,
    ST_EXISTS   = 3'd2,
    ST_NOSPACE  = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [0:0] {
    REG_GUEST_BASE  = 1'b0,
    REG_GUEST_LIMIT = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_PLACE,
    S_DONE
  } state_t;

  typedef struct packed {
    op_t                  opcode;
    logic [ADDR_BITS-1:0] host_address;
    logic [ADDR_BITS-1:0] length;
    logic [ADDR_BITS-1:0] guest_address;
    logic [3:0]           access_rights;
  } in_item_t;

  typedef struct packed {
    status_t              status;
    logic [4:0]           matched_entry;
    logic [ADDR_BITS-1:0] region_offset;
    logic [TOTAL_W-1:0]   total_mapped;
  } out_item_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] base;
    logic [ADDR_BITS-1:0] size;
  } entry_t;

  typedef struct packed {
    logic contain;
    logic overlap;
    logic exact;
  } cmp_res_t;

endpackage

>>> rtl/hrtc_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing.
module hrtc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/hrtc_cmp.sv
// Shared compare unit: relates the requested region to one stored table entry.
// Depends on hrtc_pkg.
module hrtc_cmp (
  input  logic [hrtc_pkg::ADDR_BITS-1:0] req_base,
  input  logic [hrtc_pkg::ADDR_BITS-1:0] req_len,
  input  logic [hrtc_pkg::END_W-1:0]     req_end,
  input  hrtc_pkg::entry_t               ent,
  output hrtc_pkg::cmp_res_t             res
);

  logic [hrtc_pkg::END_W-1:0] ent_b;
  logic [hrtc_pkg::END_W-1:0] ent_e;
  logic [hrtc_pkg::END_W-1:0] rb;

  always_comb begin
    ent_b = {1'b0, ent.base};
    ent_e = {1'b0, ent.base} + {1'b0, ent.size};
    rb    = {1'b0, req_base};
    res.contain = (rb >= ent_b) && (req_end <= ent_e);
    res.overlap = ((rb >= ent_b) && (rb < ent_e)) ||
                  ((req_end > ent_b) && (req_end <= ent_e)) ||
                  ((rb <= ent_b) && (req_end >= ent_e));
    res.exact   = (ent.base == req_base) && (ent.size == req_len);
  end

endmodule

>>> rtl/host_region_table_checker_unit.sv
// Top level of the host region table checker: sequencer, valid bits and totals.
// Depends on hrtc_pkg, hrtc_ram and hrtc_cmp.
//
// The block keeps a table of host memory regions and answers one request per
// item: insert, remove, guest map check or guest unmap check. An item is taken
// on the in_ channel when in_valid is high and in_stall is low; each item gives
// exactly one result item on the out_ channel, taken when out_valid is high and
// out_stall is low. The guest window registers are written through the cfg_
// channel, which is always ready.
// After an item is taken the block holds in_stall high while it works: a check
// state for the request, then a scan of the table that compares one entry per
// cycle through the registered read of the entry memory, then a place state
// for a new entry (insert only) and a done state that loads the output register.
// An unmap check, or an item that the checks reject, skips the scan; a scan ends
// at the first match or overlap, else at the last entry. No new item is taken
// before the block is back in idle.
// The result waits in the output register while out_stall is high; a new item
// may be taken meanwhile, and its result waits until the register is free.
// Synchronous reset clears all valid bits and the mapped total and sets the guest
// window registers to their reset values; no clearing pass is needed.
module host_region_table_checker_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  hrtc_pkg::in_item_t          in_item,
  output logic                        out_valid,
  input  logic                        out_stall,
  output hrtc_pkg::out_item_t         out_item,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  hrtc_pkg::cfg_reg_t          cfg_index,
  input  logic [hrtc_pkg::CFG_W-1:0]  cfg_data
);

  localparam int AW = hrtc_pkg::ADDR_BITS;
  localparam int EW = hrtc_pkg::END_W;
  localparam int IW = hrtc_pkg::IDX_W;
  localparam int PS = hrtc_pkg::PAGE_SHIFT;
  localparam int TW = hrtc_pkg::TOTAL_W;

  hrtc_pkg::state_t  state_r, state_nxt;
  hrtc_pkg::in_item_t item_r, item_nxt;
  logic [EW-1:0]     nend_r, nend_nxt;
  logic [IW:0]       ridx_r, ridx_nxt;
  logic [IW-1:0]     pidx_r, pidx_nxt;
  logic              pend_r, pend_nxt;
  logic [hrtc_pkg::ENTRIES-1:0] valid_r, valid_nxt;
  logic [TW-1:0]     total_r, total_nxt;
  hrtc_pkg::status_t res_status_r, res_status_nxt;
  logic [IW-1:0]     res_slot_r, res_slot_nxt;
  logic [AW-1:0]     res_off_r, res_off_nxt;
  logic              out_valid_r, out_valid_nxt;
  hrtc_pkg::out_item_t out_item_r, out_item_nxt;
  logic [AW-1:0]     base_r, base_nxt;
  logic [EW-1:0]     limit_r, limit_nxt;

  hrtc_pkg::entry_t   rd_ent;
  hrtc_pkg::entry_t   wr_ent;
  hrtc_pkg::cmp_res_t cmp;
  logic               wr_en;
  logic               has_free;
  logic [IW-1:0]      free_idx;
  logic               ent_vld;
  logic               last;
  logic               out_free;
  logic [EW-1:0]      sum_g;
  logic [EW-1:0]      sum_h;
  logic [AW-1:0]      gend;
  logic               win_bad;
  logic               pre_bad;
  logic               al_h;
  logic               al_l;
  logic               al_g;

  assign in_stall  = (state_r != hrtc_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;
  assign ent_vld   = valid_r[pidx_r];
  assign last      = (pidx_r == IW'(hrtc_pkg::ENTRIES - 1));

  assign wr_en  = (state_r == hrtc_pkg::S_PLACE) && has_free;
  assign wr_ent = '{base: item_r.host_address, size: item_r.length};

  hrtc_ram #(
    .WIDTH($bits(hrtc_pkg::entry_t)),
    .DEPTH(hrtc_pkg::ENTRIES)
  ) u_entries (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(free_idx),
    .wr_data(wr_ent),
    .rd_addr(ridx_r[IW-1:0]),
    .rd_data(rd_ent)
  );

  hrtc_cmp u_cmp (
    .req_base(item_r.host_address),
    .req_len (item_r.length),
    .req_end (nend_r),
    .ent     (rd_ent),
    .res     (cmp)
  );

  always_comb begin
    has_free = 1'b0;
    free_idx = '0;
    for (int i = hrtc_pkg::ENTRIES - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        has_free = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  always_comb begin
    sum_g   = {1'b0, item_r.guest_address} + {1'b0, item_r.length};
    sum_h   = {1'b0, item_r.host_address} + {1'b0, item_r.length};
    gend    = sum_g[AW-1:0];
    al_h    = (item_r.host_address[PS-1:0] == '0);
    al_l    = (item_r.length[PS-1:0] == '0);
    al_g    = (item_r.guest_address[PS-1:0] == '0);
    win_bad = (item_r.guest_address < base_r) ||
              ({1'b0, item_r.guest_address} >= limit_r) ||
              ({1'b0, gend} > limit_r);
    case (item_r.opcode)
      hrtc_pkg::OP_INSERT: pre_bad = !al_h || !al_l || (item_r.host_address == '0) ||
                                     (sum_h[AW-1:0] <= item_r.host_address);
      hrtc_pkg::OP_REMOVE: pre_bad = 1'b0;
      hrtc_pkg::OP_MAP:    pre_bad = item_r.access_rights[3] ||
                                     (gend <= item_r.guest_address) ||
                                     !al_g || !al_l || !al_h ||
                                     (item_r.host_address == '0) || win_bad;
      hrtc_pkg::OP_UNMAP:  pre_bad = (gend <= item_r.guest_address) ||
                                     !al_g || !al_l || win_bad;
      default:             pre_bad = 1'b1;
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hrtc_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = hrtc_pkg::S_CHECK;
        end
      end
      hrtc_pkg::S_CHECK: begin
        if (pre_bad || item_r.opcode == hrtc_pkg::OP_UNMAP) begin
          state_nxt = hrtc_pkg::S_DONE;
        end else begin
          state_nxt = hrtc_pkg::S_SCAN;
        end
      end
      hrtc_pkg::S_SCAN: begin
        if (pend_r) begin
          case (item_r.opcode)
            hrtc_pkg::OP_INSERT: begin
              if (ent_vld && cmp.contain) begin
                state_nxt = hrtc_pkg::S_PLACE;
              end else if (ent_vld && cmp.overlap) begin
                state_nxt = hrtc_pkg::S_DONE;
              end else if (last) begin
                state_nxt = hrtc_pkg::S_PLACE;
              end
            end
            hrtc_pkg::OP_REMOVE: begin
              if ((ent_vld && cmp.exact) || last) begin
                state_nxt = hrtc_pkg::S_DONE;
              end
            end
            default: begin
              if ((ent_vld && cmp.contain) || last) begin
                state_nxt = hrtc_pkg::S_DONE;
              end
            end
          endcase
        end
      end
      hrtc_pkg::S_PLACE: state_nxt = hrtc_pkg::S_DONE;
      hrtc_pkg::S_DONE: begin
        if (out_free) begin
          state_nxt = hrtc_pkg::S_IDLE;
        end
      end
      default: state_nxt = hrtc_pkg::S_IDLE;
    endcase
  end

  // Datapath and output register.
  always_comb begin
    item_nxt       = item_r;
    nend_nxt       = nend_r;
    ridx_nxt       = ridx_r;
    pidx_nxt       = pidx_r;
    pend_nxt       = 1'b0;
    valid_nxt      = valid_r;
    total_nxt      = total_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_off_nxt    = res_off_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_item_nxt   = out_item_r;
    base_nxt       = base_r;
    limit_nxt      = limit_r;

    if (cfg_valid) begin
      case (cfg_index)
        hrtc_pkg::REG_GUEST_BASE:  base_nxt  = cfg_data[AW-1:0];
        hrtc_pkg::REG_GUEST_LIMIT: limit_nxt = cfg_data[EW-1:0];
        default: ;
      endcase
    end

    case (state_r)
      hrtc_pkg::S_IDLE: begin
        if (in_valid) begin
          item_nxt = in_item;
        end
      end
      hrtc_pkg::S_CHECK: begin
        ridx_nxt       = '0;
        res_slot_nxt   = '0;
        res_off_nxt    = '0;
        res_status_nxt = pre_bad ? hrtc_pkg::ST_INVALID : hrtc_pkg::ST_OK;
        nend_nxt       = (item_r.opcode == hrtc_pkg::OP_MAP) ? sum_h
                                                              : {1'b0, sum_h[AW-1:0]};
      end
      hrtc_pkg::S_SCAN: begin
        if (ridx_r < (IW + 1)'(hrtc_pkg::ENTRIES)) begin
          ridx_nxt = ridx_r + (IW + 1)'(1);
          pidx_nxt = ridx_r[IW-1:0];
          pend_nxt = 1'b1;
        end
        if (pend_r) begin
          case (item_r.opcode)
            hrtc_pkg::OP_INSERT: begin
              if (ent_vld && !cmp.contain && cmp.overlap) begin
                res_status_nxt = hrtc_pkg::ST_EXISTS;
              end
            end
            hrtc_pkg::OP_REMOVE: begin
              if (ent_vld && cmp.exact) begin
                valid_nxt[pidx_r] = 1'b0;
                total_nxt         = total_r - {{(TW - AW){1'b0}}, item_r.length};
                res_slot_nxt      = pidx_r;
              end else if (last) begin
                res_status_nxt = hrtc_pkg::ST_NOTFOUND;
              end
            end
            default: begin
              if (ent_vld && cmp.contain) begin
                res_slot_nxt = pidx_r;
                res_off_nxt  = item_r.host_address - rd_ent.base;
              end else if (last) begin
                res_status_nxt = hrtc_pkg::ST_INVALID;
              end
            end
          endcase
        end
      end
      hrtc_pkg::S_PLACE: begin
        if (has_free) begin
          valid_nxt[free_idx] = 1'b1;
          total_nxt           = total_r + {{(TW - AW){1'b0}}, item_r.length};
          res_slot_nxt        = free_idx;
        end else begin
          res_status_nxt = hrtc_pkg::ST_NOSPACE;
        end
      end
      hrtc_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_nxt              = 1'b1;
          out_item_nxt.status        = res_status_r;
          out_item_nxt.matched_entry = 5'(res_slot_r);
          out_item_nxt.region_offset = res_off_r;
          out_item_nxt.total_mapped  = total_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hrtc_pkg::S_IDLE;
      pend_r      <= 1'b0;
      valid_r     <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      base_r      <= hrtc_pkg::GUEST_BASE_RESET;
      limit_r     <= hrtc_pkg::GUEST_LIMIT_RESET;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      valid_r     <= valid_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      base_r      <= base_nxt;
      limit_r     <= limit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r       <= item_nxt;
    nend_r       <= nend_nxt;
    ridx_r       <= ridx_nxt;
    pidx_r       <= pidx_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_off_r    <= res_off_nxt;
    out_item_r   <= out_item_nxt;
  end

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
// Testbench for host_region_table_checker_unit: a queue-fed driver, a predictor of the
// region table and guest window checks, and a monitor comparing every result item.
// Depends on hrtc_pkg and the block's RTL only.
module tb;
  import hrtc_pkg::*;

  localparam logic [63:0] ADDR_MASK = (64'd1 << ADDR_BITS) - 1;
  localparam logic [63:0] PG = 64'(PAGE_BYTES);
  localparam int RANDOM_PER_PHASE = 150;
  localparam int LONG_HOLD = 400;
  localparam int CYCLE_LIMIT = 600000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  cfg_reg_t cfg_index = REG_GUEST_BASE;
  logic [CFG_W-1:0] cfg_data = '0;

  logic tbl_valid [ENTRIES] = '{default: 1'b0};
  logic [ADDR_BITS-1:0] tbl_base [ENTRIES];
  logic [ADDR_BITS-1:0] tbl_size [ENTRIES];
  logic [TOTAL_W-1:0] tbl_total = '0;
  logic [ADDR_BITS-1:0] win_base = GUEST_BASE_RESET;
  logic [END_W-1:0] win_limit = GUEST_LIMIT_RESET;

  in_item_t request_queue [$];
  out_item_t expected_replies [$];
  logic [ADDR_BITS-1:0] known_base [$];
  logic [ADDR_BITS-1:0] known_size [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_start = 1'b0;
  int hold_left = 0;
  int failures = 0;
  int cycle_count = 0;
  out_item_t want;

  host_region_table_checker_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  function automatic logic page_aligned(logic [63:0] v);
    return (v % PG) == 0;
  endfunction

  function automatic logic in_window(logic [63:0] gpa, logic [63:0] gend);
    return gpa >= 64'(win_base) && gpa < 64'(win_limit) && gend <= 64'(win_limit);
  endfunction

  function automatic out_item_t predict_table_op(in_item_t it);
    out_item_t r;
    logic [63:0] hva, len, gpa, hend, gend, b, e;
    status_t st;
    int slot;
    logic [ADDR_BITS-1:0] off;
    hva = 64'(it.host_address);
    len = 64'(it.length);
    gpa = 64'(it.guest_address);
    gend = (gpa + len) & ADDR_MASK;
    st = ST_INVALID;
    slot = 0;
    off = '0;
    case (it.opcode)
      OP_INSERT: begin
        hend = (hva + len) & ADDR_MASK;
        if (page_aligned(hva) && page_aligned(len) && hva != 0 && hend > hva) begin
          st = ST_OK;
          for (int i = 0; i < ENTRIES; i++) begin
            if (tbl_valid[i]) begin
              b = 64'(tbl_base[i]);
              e = b + 64'(tbl_size[i]);
              if (hva >= b && hend <= e) break;
              if ((hva >= b && hva < e) || (hend > b && hend <= e) ||
                  (hva <= b && hend >= e)) begin
                st = ST_EXISTS;
                break;
              end
            end
          end
          if (st == ST_OK) begin
            st = ST_NOSPACE;
            for (int i = 0; i < ENTRIES; i++) begin
              if (!tbl_valid[i]) begin
                tbl_valid[i] = 1'b1;
                tbl_base[i] = it.host_address;
                tbl_size[i] = it.length;
                tbl_total = tbl_total + TOTAL_W'(len);
                slot = i;
                st = ST_OK;
                break;
              end
            end
          end
        end
      end
      OP_REMOVE: begin
        st = ST_NOTFOUND;
        for (int i = 0; i < ENTRIES; i++) begin
          if (tbl_valid[i] && tbl_base[i] == it.host_address &&
              tbl_size[i] == it.length) begin
            tbl_valid[i] = 1'b0;
            tbl_total = tbl_total - TOTAL_W'(len);
            slot = i;
            st = ST_OK;
            break;
          end
        end
      end
      OP_MAP: begin
        hend = hva + len;
        if (!it.access_rights[3] && gend > gpa && page_aligned(gpa) &&
            page_aligned(len) && page_aligned(hva) && hva != 0 &&
            in_window(gpa, gend)) begin
          for (int i = 0; i < ENTRIES; i++) begin
            b = 64'(tbl_base[i]);
            if (tbl_valid[i] && hva >= b && hend <= b + 64'(tbl_size[i])) begin
              slot = i;
              off = ADDR_BITS'(hva - b);
              st = ST_OK;
              break;
            end
          end
        end
      end
      default: begin
        if (gend > gpa && page_aligned(gpa) && page_aligned(len) && in_window(gpa, gend)) begin
          st = ST_OK;
        end
      end
    endcase
    r.status = st;
    r.matched_entry = (st == ST_OK && it.opcode != OP_UNMAP) ? 5'(slot) : 5'd0;
    r.region_offset = (st == ST_OK) ? off : '0;
    r.total_mapped = tbl_total;
    return r;
  endfunction

  function automatic logic [ADDR_BITS-1:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic in_item_t mk_item(op_t op, logic [63:0] hva, logic [63:0] len,
                                       logic [63:0] gpa, logic [3:0] prot);
    in_item_t it;
    it.opcode = op;
    it.host_address = ADDR_BITS'(hva);
    it.length = ADDR_BITS'(len);
    it.guest_address = ADDR_BITS'(gpa);
    it.access_rights = prot;
    return it;
  endfunction

  function automatic logic [63:0] window_gpa(int npages);
    logic [63:0] lo, hi;
    lo = (64'(win_base) + PG - 1) & ~(PG - 1);
    hi = 64'(win_limit) & ~(PG - 1);
    if ($urandom_range(0, 3) == 0 && hi >= 64'(npages) * PG)
      return (hi - 64'(npages) * PG) & ADDR_MASK;
    return (lo + 64'($urandom_range(0, 255)) * PG) & ADDR_MASK;
  endfunction

  function automatic in_item_t gen_table_item();
    in_item_t it;
    int sel, j, pages, first, n;
    it = mk_item(op_t'($urandom_range(0, 3)), rand48(), rand48(), rand48(), 4'($urandom));
    sel = $urandom_range(0, 99);
    if (sel < 8) return it;
    if (sel < 45 && !(known_base.size() > 28 && $urandom_range(0, 1) == 1)) begin
      it.opcode = OP_INSERT;
      if ($urandom_range(0, 3) == 0 && known_base.size() > 0) begin
        j = $urandom_range(0, known_base.size() - 1);
        pages = int'(known_size[j] / PG);
        first = $urandom_range(0, pages - 1);
        n = $urandom_range(1, pages - first);
        it.host_address = known_base[j] + ADDR_BITS'(64'(first) * PG);
        it.length = ADDR_BITS'(64'(n) * PG);
      end else begin
        it.host_address = ADDR_BITS'(64'($urandom_range(1, 256)) * PG);
        if ($urandom_range(0, 9) == 0)
          it.host_address = rand48() & ~ADDR_BITS'(PG - 1);
        it.length = ADDR_BITS'(64'($urandom_range(1, 16)) * PG);
        known_base.push_back(it.host_address);
        known_size.push_back(it.length);
      end
    end else if (sel < 65) begin
      it.opcode = OP_REMOVE;
      if ($urandom_range(0, 9) < 7 && known_base.size() > 0) begin
        j = $urandom_range(0, known_base.size() - 1);
        it.host_address = known_base[j];
        it.length = known_size[j];
        known_base.delete(j);
        known_size.delete(j);
      end else begin
        it.host_address = ADDR_BITS'(64'($urandom_range(1, 256)) * PG);
        it.length = ADDR_BITS'(64'($urandom_range(1, 16)) * PG);
      end
    end else if (sel < 90) begin
      it.opcode = OP_MAP;
      it.access_rights = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, 7));
      if (known_base.size() > 0) begin
        j = $urandom_range(0, known_base.size() - 1);
        pages = int'(known_size[j] / PG);
        first = $urandom_range(0, pages - 1);
        n = $urandom_range(1, pages - first);
        it.host_address = known_base[j] + ADDR_BITS'(64'(first) * PG);
        it.length = ADDR_BITS'(64'(n) * PG);
      end else begin
        n = $urandom_range(1, 4);
        it.length = ADDR_BITS'(64'(n) * PG);
      end
      it.guest_address = ADDR_BITS'(window_gpa(n));
      case ($urandom_range(0, 19))
        0: it.host_address = rand48();
        1: it.guest_address = rand48();
        2: it.length = rand48();
        default: ;
      endcase
    end else begin
      it.opcode = OP_UNMAP;
      n = $urandom_range(1, 8);
      it.length = ADDR_BITS'(64'(n) * PG);
      it.guest_address = ADDR_BITS'(window_gpa(n));
      if ($urandom_range(0, 9) == 0) it.length = rand48();
    end
    return it;
  endfunction

  task automatic write_window_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_GUEST_BASE) win_base = val[ADDR_BITS-1:0];
    else win_limit = val[END_W-1:0];
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (request_queue.size() != 0 || in_valid || expected_replies.size() != 0);
  endtask

  task automatic run_random(int count);
    repeat (count) request_queue.push_back(gen_table_item());
    wait_drained();
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_replies.push_back(predict_table_op(in_item));
      if (!(in_valid && in_stall)) begin
        if (request_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_item <= request_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else begin
      if (hold_start) hold_left <= LONG_HOLD;
      else if (hold_left > 0) hold_left <= hold_left - 1;
      out_stall <= hold_start || hold_left > 1 || $urandom_range(0, 99) < recv_stall_pct;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_replies.size() == 0) begin
        $error("result item with no request outstanding");
        failures++;
      end else begin
        want = expected_replies.pop_front();
        if (out_item.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_item.status);
          failures++;
        end
        if (out_item.matched_entry !== want.matched_entry) begin
          $error("matched_entry: expected %0d, got %0d", want.matched_entry,
                 out_item.matched_entry);
          failures++;
        end
        if (out_item.region_offset !== want.region_offset) begin
          $error("region_offset: expected %h, got %h", want.region_offset,
                 out_item.region_offset);
          failures++;
        end
        if (out_item.total_mapped !== want.total_mapped) begin
          $error("total_mapped: expected %h, got %h", want.total_mapped,
                 out_item.total_mapped);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    logic [63:0] top, lim;
    top = 64'd1 << ADDR_BITS;
    lim = 64'(GUEST_LIMIT_RESET);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    request_queue.push_back(mk_item(OP_INSERT, 0, PG, 0, 4'h0));
    request_queue.push_back(mk_item(OP_INSERT, 64'h1800, PG, 0, 4'h1));
    request_queue.push_back(mk_item(OP_INSERT, 64'h1000, 64'h800, 0, 4'h2));
    request_queue.push_back(mk_item(OP_INSERT, 64'h1000, 0, 0, 4'h4));
    request_queue.push_back(mk_item(OP_INSERT, top - PG, PG, 0, 4'h8));
    request_queue.push_back(mk_item(OP_INSERT, top - 2 * PG, PG, ADDR_MASK, 4'hf));
    request_queue.push_back(mk_item(OP_INSERT, 64'h10000, 64'h10000, 0, 4'h0));
    request_queue.push_back(mk_item(OP_INSERT, 64'h12000, 64'h2000, 0, 4'h0));
    request_queue.push_back(mk_item(OP_INSERT, 64'h1f000, 64'h2000, 0, 4'h0));
    request_queue.push_back(mk_item(OP_INSERT, 64'hf000, 64'h2000, 0, 4'h0));
    request_queue.push_back(mk_item(OP_INSERT, 64'h8000, 64'h20000, 0, 4'h0));
    request_queue.push_back(mk_item(OP_REMOVE, 64'h12000, 64'h2000, 0, 4'h0));
    request_queue.push_back(mk_item(OP_REMOVE, 64'h10000, 64'h1000, 0, 4'h0));
    request_queue.push_back(mk_item(OP_MAP, 64'h11000, PG, 64'h3000, 4'h3));
    request_queue.push_back(mk_item(OP_MAP, 64'h11000, PG, 64'h3000, 4'hf));
    request_queue.push_back(mk_item(OP_MAP, 64'h11000, 0, 64'h3000, 4'h1));
    request_queue.push_back(mk_item(OP_MAP, 64'h11000, PG, top - PG, 4'h1));
    request_queue.push_back(mk_item(OP_MAP, 64'h11000, PG, 64'h3800, 4'h1));
    request_queue.push_back(mk_item(OP_MAP, 0, PG, 64'h3000, 4'h1));
    request_queue.push_back(mk_item(OP_MAP, 64'h11000, PG, lim, 4'h1));
    request_queue.push_back(mk_item(OP_MAP, 64'h11000, 2 * PG, lim - PG, 4'h1));
    request_queue.push_back(mk_item(OP_MAP, 64'h30000, PG, 64'h3000, 4'h7));
    request_queue.push_back(mk_item(OP_UNMAP, 0, PG, lim - PG, 4'h0));
    request_queue.push_back(mk_item(OP_UNMAP, 0, 64'h800, 64'h3000, 4'h0));
    request_queue.push_back(mk_item(OP_UNMAP, 0, PG, lim, 4'h0));
    wait_drained();
    run_random(RANDOM_PER_PHASE);

    write_window_reg(REG_GUEST_BASE, '0);
    write_window_reg(REG_GUEST_LIMIT, CFG_W'(top));
    send_idle_pct = 58;
    repeat (34) request_queue.push_back(mk_item(OP_INSERT, 64'h4000_0000_0000, 2 * PG, 0, 4'h0));
    repeat (34) request_queue.push_back(mk_item(OP_REMOVE, 64'h4000_0000_0000, 2 * PG, 0, 4'h0));
    run_random(RANDOM_PER_PHASE);

    write_window_reg(REG_GUEST_BASE, CFG_W'($urandom_range(1, 32'h7fff_ffff)) << 5);
    write_window_reg(REG_GUEST_LIMIT, CFG_W'(win_base) + (CFG_W'(1) << 32) + CFG_W'($urandom));
    send_idle_pct = 0;
    recv_stall_pct = 58;
    @(posedge clk);
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    request_queue.push_back(mk_item(OP_MAP, 64'h11000, PG,
                                    (64'(win_base) & ~(PG - 1)) - PG, 4'h1));
    request_queue.push_back(mk_item(OP_UNMAP, 0, PG, (64'(win_base) & ~(PG - 1)) - PG, 4'h0));
    run_random(RANDOM_PER_PHASE);

    write_window_reg(REG_GUEST_BASE, CFG_W'(ADDR_MASK));
    write_window_reg(REG_GUEST_LIMIT, '0);
    send_idle_pct = 37;
    recv_stall_pct = 37;
    run_random(RANDOM_PER_PHASE / 2);

    write_window_reg(REG_GUEST_BASE, CFG_W'(PG));
    write_window_reg(REG_GUEST_LIMIT, (CFG_W'(1) << 40) + CFG_W'(12'h800));
    run_random(RANDOM_PER_PHASE);

    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_random(RANDOM_PER_PHASE / 2);

    repeat (60) @(posedge clk);
    if (failures == 0 && expected_replies.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
